[rtl/rscb_pkg.sv]
// shared constants for the rle sprite clip blitter
package rscb_pkg;

	// default module parameters
	localparam int DEF_LINE_PITCH    = 320;
	localparam int DEF_MAX_ROW_WIDTH = 1023;

	// field widths
	localparam int COL_W  = 10;
	localparam int ROW_W  = 9;
	localparam int ADDR_W = 16;
	localparam int BYTE_W = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// decode phases
	localparam logic [1:0] PH_CONTROL = 2'd0;
	localparam logic [1:0] PH_REPEAT  = 2'd1;
	localparam logic [1:0] PH_LITERAL = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_ROWS     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DRAW_ROWS     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VISIBLE_START = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VISIBLE_END   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_START_ADDRESS = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MIRROR_X      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MIRROR_Y      = 3'd7;

endpackage

[rtl/rle_sprite_clip_blitter.sv]
// top level of the rle sprite clip blitter: decode, clip and address generation
//
// Usage:
//  - s_* stream: one rle byte per word, s_tdata = stream_byte, s_tuser = frame_start.
//    A word with frame_start restarts decoding; that byte is the first control byte.
//  - m_* stream: exactly one result word per input word. m_tdata holds write_address,
//    pixel_value and span_length, m_tuser is write_enable, m_tlast is sprite_done.
//    A result with write_enable low carries all-zero data (control bytes, clipped
//    pixels, skipped rows, idle bytes).
//  - cfg_* channel: register writes, always ready; write only while the block is idle.
//  - output: each result is registered and appears in the cycle after its byte is accepted.
//  - throughput: one byte per cycle while the receiver takes results; decode, clip and
//    address logic sit between the state registers and the single result register.
//  - when the receiver stalls, the result register holds and s_tready drops until
//    the result is taken; s_tready is high while the result register is empty or
//    being drained in the same cycle.
//  - reset: configuration and state registers take their default values, the decoder idles
//    with the sprite marked finished until a frame_start word arrives.
module rle_sprite_clip_blitter
	import rscb_pkg::*;
#(
	parameter int LINE_PITCH    = DEF_LINE_PITCH,
	parameter int MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] stream_byte
	input  logic [0:0]            s_tuser,   // [0] frame_start
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [31:0]           m_tdata,   // [15:0] write_address, [23:16] pixel_value,
	                                         // [31:24] span_length
	output logic [0:0]            m_tuser,   // [0] write_enable
	output logic                  m_tlast,   // sprite_done
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// row width limit and pitch folded into the field widths
	localparam int MAX_W_INT = (MAX_ROW_WIDTH > 1023) ? 1023 : MAX_ROW_WIDTH;
	localparam logic [COL_W-1:0]  MAX_W = COL_W'(MAX_W_INT);
	localparam logic [ADDR_W-1:0] PITCH = ADDR_W'(LINE_PITCH);

	// configuration registers
	logic [COL_W-1:0]  row_width_q;
	logic [7:0]        skip_rows_q;
	logic [7:0]        draw_rows_q;
	logic [COL_W-1:0]  vis_start_q;
	logic [COL_W-1:0]  vis_end_q;
	logic [ADDR_W-1:0] start_addr_q;
	logic              mirror_x_q;
	logic              mirror_y_q;

	// decoder state
	logic [1:0]        phase_q;
	logic [7:0]        run_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] base_q;
	logic              fin_q;

	// next state and result
	logic [1:0]        n_phase;
	logic [7:0]        n_run;
	logic [COL_W-1:0]  n_col;
	logic [ROW_W-1:0]  n_row;
	logic [ADDR_W-1:0] n_base;
	logic              n_fin;
	logic              o_we;
	logic [ADDR_W-1:0] o_addr;
	logic [7:0]        o_pix;
	logic [7:0]        o_len;
	logic              o_done;

	// working values
	logic              fs;
	logic [7:0]        sbyte;
	logic [1:0]        e_phase;
	logic [7:0]        e_run;
	logic [COL_W-1:0]  e_col;
	logic [ROW_W-1:0]  e_row;
	logic [ADDR_W-1:0] e_base;
	logic              e_fin;
	logic [COL_W-1:0]  width;
	logic [ROW_W-1:0]  total;
	logic              drawn;
	logic [COL_W:0]    run_end;
	logic [COL_W-1:0]  ce1;
	logic [COL_W-1:0]  ce;
	logic [COL_W-1:0]  cs;
	logic [COL_W-1:0]  em_col;
	logic [COL_W-1:0]  off;
	logic [COL_W-1:0]  lit_col;
	logic [7:0]        lit_run;
	logic              fin_req;
	logic [COL_W:0]    fin_end;

	logic accept;

	assign cfg_ready = 1'b1;
	assign s_tready  = !m_tvalid || m_tready;
	assign accept    = s_tvalid && s_tready;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q  <= COL_W'(1);
			skip_rows_q  <= '0;
			draw_rows_q  <= 8'd1;
			vis_start_q  <= '0;
			vis_end_q    <= '0;
			start_addr_q <= '0;
			mirror_x_q   <= 1'b0;
			mirror_y_q   <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ROW_WIDTH:     row_width_q  <= cfg_data[COL_W-1:0];
				REG_SKIP_ROWS:     skip_rows_q  <= cfg_data[7:0];
				REG_DRAW_ROWS:     draw_rows_q  <= cfg_data[7:0];
				REG_VISIBLE_START: vis_start_q  <= cfg_data[COL_W-1:0];
				REG_VISIBLE_END:   vis_end_q    <= cfg_data[COL_W-1:0];
				REG_START_ADDRESS: start_addr_q <= cfg_data[ADDR_W-1:0];
				REG_MIRROR_X:      mirror_x_q   <= cfg_data[0];
				REG_MIRROR_Y:      mirror_y_q   <= cfg_data[0];
			endcase
		end
	end

	// decode, clip and address for one byte
	always_comb begin
		fs    = s_tuser[0];
		sbyte = s_tdata[7:0];

		// frame start restarts the sprite before the byte is decoded
		e_phase = fs ? PH_CONTROL : phase_q;
		e_run   = fs ? 8'd0 : run_q;
		e_col   = fs ? '0 : col_q;
		e_row   = fs ? '0 : row_q;
		e_base  = fs ? start_addr_q : base_q;
		e_fin   = fs ? 1'b0 : fin_q;

		n_phase = e_phase;
		n_run   = e_run;
		n_col   = e_col;
		n_row   = e_row;
		n_base  = e_base;
		n_fin   = e_fin;

		o_we   = 1'b0;
		o_addr = '0;
		o_pix  = '0;
		o_len  = '0;
		o_done = 1'b0;

		width = (row_width_q < MAX_W) ? row_width_q : MAX_W;
		total = ROW_W'(skip_rows_q) + ROW_W'(draw_rows_q);
		drawn = (e_row >= ROW_W'(skip_rows_q)) && (e_row < total);

		// repeat run clip window
		run_end = {1'b0, e_col} + (COL_W+1)'(e_run);
		ce1     = (run_end < {1'b0, width}) ? run_end[COL_W-1:0] : width;
		ce      = (ce1 > vis_end_q) ? vis_end_q : ce1;
		cs      = (e_col > vis_start_q) ? e_col : vis_start_q;

		// address of the first written pixel
		em_col = (e_phase == PH_REPEAT) ? cs : e_col;
		off    = em_col - vis_start_q;

		// literal column advance
		lit_col = (e_col < width) ? e_col + COL_W'(1) : e_col;
		lit_run = e_run - 8'd1;

		fin_req = 1'b0;
		fin_end = '0;

		if (!e_fin) begin
			unique case (e_phase)
				PH_REPEAT: begin
					if (drawn && cs < ce) begin
						o_we  = 1'b1;
						o_pix = sbyte;
						o_len = 8'(ce - cs);
					end
					fin_req = 1'b1;
					fin_end = run_end;
				end
				PH_LITERAL: begin
					if (drawn && e_col < width && e_col >= vis_start_q && e_col < vis_end_q) begin
						o_we  = 1'b1;
						o_pix = sbyte;
						o_len = 8'd1;
					end
					n_col = lit_col;
					n_run = lit_run;
					if (lit_run == 8'd0) begin
						fin_req = 1'b1;
						fin_end = {1'b0, lit_col};
					end
				end
				default: begin
					// control byte
					if (sbyte[7]) begin
						n_run   = 8'(9'd257 - {1'b0, sbyte});
						n_phase = PH_REPEAT;
					end else begin
						n_run   = sbyte + 8'd1;
						n_phase = PH_LITERAL;
					end
				end
			endcase

			if (o_we) begin
				o_addr = mirror_x_q ? (e_base - ADDR_W'(off)) : (e_base + ADDR_W'(off));
			end

			// end of run, possibly end of row and sprite
			if (fin_req) begin
				n_phase = PH_CONTROL;
				n_run   = '0;
				if (fin_end < {1'b0, width}) begin
					n_col = fin_end[COL_W-1:0];
				end else begin
					n_col = '0;
					if (drawn) begin
						n_base = mirror_y_q ? (e_base - PITCH) : (e_base + PITCH);
					end
					n_row = e_row + ROW_W'(1);
					if (n_row >= total) begin
						n_fin  = 1'b1;
						o_done = 1'b1;
					end
				end
			end
		end
	end

	// decoder state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CONTROL;
			run_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
			base_q  <= '0;
			fin_q   <= 1'b1;
		end else if (accept) begin
			phase_q <= n_phase;
			run_q   <= n_run;
			col_q   <= n_col;
			row_q   <= n_row;
			base_q  <= n_base;
			fin_q   <= n_fin;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (accept) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata    <= {o_len, o_pix, o_addr};
			m_tuser[0] <= o_we;
			m_tlast    <= o_done;
		end
	end

	// no write means an all-zero data word
	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == 32'd0))
		else $error("data not zero on a result without write");

	// every write covers at least one pixel
	a_span_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[31:24] != 8'd0))
		else $error("write with empty span");

	// idle decoder gives an empty result
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && fin_q && !s_tuser[0]) |=>
		(m_tvalid && !m_tuser[0] && !m_tlast && $stable(phase_q) && $stable(row_q)))
		else $error("idle byte changed state or produced a result");

	// a run count is only held outside the control phase
	a_control_run: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_CONTROL) |-> (run_q == 8'd0))
		else $error("run count left over in control phase");

	// literal phase always has bytes left
	a_literal_run: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LITERAL) |-> (run_q != 8'd0))
		else $error("literal phase with no bytes left");

endmodule
